>>> sv/rleq_pkg.sv
// shared types and constants for the rate limited event queue
// no dependencies; used by every module of the block except rleq_ram

package rleq_pkg;

  // default ring depth
  localparam int unsigned QUEUE_DEPTH_DEF = 16;

  // register reset values
  localparam logic [31:0] SEND_GAP_RST = 32'd1000;
  localparam logic [31:0] SYNC_GAP_RST = 32'd5000;

  // request codes
  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_ENQ  = 1'b1;

  // configuration register indexes
  localparam logic CFG_SEND_GAP = 1'b0;
  localparam logic CFG_SYNC_GAP = 1'b1;

  // one stored event
  typedef struct packed {
    logic [1:0]  compartment;
    logic [1:0]  kind;
    logic [31:0] value;
    logic [30:0] stamp;
  } event_t;

  // ring commands for the current transaction
  typedef struct packed {
    logic push;
    logic pop;
  } ring_cmd_t;

  // ring status before the current transaction
  typedef struct packed {
    logic empty;
    logic full;
  } ring_sts_t;

  // timer stamp updates
  typedef struct packed {
    logic attempt;
    logic sync;
  } timer_upd_t;

  // timer compare results
  typedef struct packed {
    logic send;
    logic sync;
  } timer_due_t;

endpackage

>>> sv/rleq_ram.sv
// generic single write port ram with one registered read port
// no dependencies

module rleq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read, old data on a same-address write
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/rleq_ring.sv
// event ring: pointers, occupancy, head register and event storage
// depends on rleq_pkg and rleq_ram

module rleq_ring #(
  parameter int unsigned QUEUE_DEPTH = rleq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  rleq_pkg::ring_cmd_t                  cmd_i,
  input  rleq_pkg::event_t                     wdata_i,
  output rleq_pkg::event_t                     head_o,
  output rleq_pkg::ring_sts_t                  sts_o,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]     occ_nxt_o
);

  localparam int unsigned AW    = $clog2(QUEUE_DEPTH);
  localparam int unsigned OCC_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned EW    = $bits(rleq_pkg::event_t);

  logic [AW-1:0]    rd_q, rd_d;
  logic [AW-1:0]    wr_q, wr_d;
  logic [OCC_W-1:0] occ_q, occ_d;
  rleq_pkg::event_t head_q, head_d;
  logic [AW-1:0]    ram_raddr;
  logic [EW-1:0]    ram_rdata;
  logic             fwd_q, fwd_d;
  rleq_pkg::event_t fwd_data_q;
  rleq_pkg::event_t next_entry;

  function automatic logic [AW-1:0] slot_inc(input logic [AW-1:0] s);
    if (s == AW'(QUEUE_DEPTH - 1)) begin
      slot_inc = '0;
    end else begin
      slot_inc = s + AW'(1);
    end
  endfunction

  // status before this transaction
  assign sts_o.empty = (occ_q == '0);
  assign sts_o.full  = (occ_q == OCC_W'(QUEUE_DEPTH));

  // pointer and occupancy update
  always_comb begin
    rd_d  = cmd_i.pop  ? slot_inc(rd_q) : rd_q;
    wr_d  = cmd_i.push ? slot_inc(wr_q) : wr_q;
    occ_d = occ_q;
    case ({cmd_i.push, cmd_i.pop})
      2'b10:   occ_d = occ_q + OCC_W'(1);
      2'b01:   occ_d = occ_q - OCC_W'(1);
      default: occ_d = occ_q;
    endcase
  end

  assign occ_nxt_o = occ_d;

  // storage keeps the entry after the head ready at its registered read port
  assign ram_raddr = slot_inc(rd_d);
  assign fwd_d     = cmd_i.push && (wr_q == ram_raddr);

  rleq_ram #(
    .WIDTH (EW),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.push),
    .waddr_i (wr_q),
    .wdata_i (wdata_i),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // bypass a write that hit the read address at the same edge
  assign next_entry = fwd_q ? fwd_data_q : rleq_pkg::event_t'(ram_rdata);

  // head register follows the oldest entry
  always_comb begin
    head_d = head_q;
    if (cmd_i.pop) begin
      head_d = next_entry;
    end else if (cmd_i.push && sts_o.empty) begin
      head_d = wdata_i;
    end
  end

  assign head_o = head_q;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q  <= '0;
      wr_q  <= '0;
      occ_q <= '0;
      fwd_q <= 1'b0;
    end else begin
      rd_q  <= rd_d;
      wr_q  <= wr_d;
      occ_q <= occ_d;
      fwd_q <= fwd_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    head_q     <= head_d;
    fwd_data_q <= wdata_i;
  end

endmodule

>>> sv/rleq_timers.sv
// send and sync interval timers with their gap registers
// depends on rleq_pkg

module rleq_timers (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic                   cfg_idx_i,
  input  logic [31:0]            cfg_wdata_i,
  input  logic [31:0]            now_i,
  input  rleq_pkg::timer_upd_t   upd_i,
  output rleq_pkg::timer_due_t   due_o
);

  logic [31:0] send_gap_q;
  logic [31:0] sync_gap_q;
  logic [31:0] last_attempt_q;
  logic [31:0] last_sync_q;
  logic [31:0] send_age;
  logic [31:0] sync_age;

  // modular elapsed time, strict compare
  assign send_age     = now_i - last_attempt_q;
  assign sync_age     = now_i - last_sync_q;
  assign due_o.send   = (send_age > send_gap_q);
  assign due_o.sync   = (sync_age > sync_gap_q);

  // gap registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      send_gap_q <= rleq_pkg::SEND_GAP_RST;
      sync_gap_q <= rleq_pkg::SYNC_GAP_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rleq_pkg::CFG_SEND_GAP: send_gap_q <= cfg_wdata_i;
        rleq_pkg::CFG_SYNC_GAP: sync_gap_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // last attempt and last sync stamps
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_attempt_q <= '0;
      last_sync_q    <= '0;
    end else begin
      if (upd_i.attempt) begin
        last_attempt_q <= now_i;
      end
      if (upd_i.sync) begin
        last_sync_q <= now_i;
      end
    end
  end

endmodule

>>> sv/rate_limited_event_queue_top.sv
// rate limited event queue: input register, ring, timers, result register
// transactions pass the input register, then the result register; the head entry
// sits in a register and the ring memory pre-reads the entry behind it, so a pop
// never waits on a read; throughput: one transaction per cycle when out_stall_i is low
// reset: pointers, occupancy and time stamps clear, gaps return to 1000 / 5000 ms;
// ring contents stay undefined, no clearing pass

module rate_limited_event_queue_top #(
  parameter int unsigned QUEUE_DEPTH = rleq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        req_type_i,
  input  logic [31:0] now_ms_i,
  input  logic        link_up_i,
  input  logic        send_accepted_i,
  input  logic [1:0]  compartment_i,
  input  logic [1:0]  event_kind_i,
  input  logic [31:0] event_value_i,
  input  logic [30:0] stamp_minutes_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        send_valid_o,
  output logic [1:0]  out_compartment_o,
  output logic [1:0]  out_kind_o,
  output logic [31:0] out_value_o,
  output logic [30:0] out_stamp_o,
  output logic        sync_request_o,
  output logic        dropped_oldest_o,
  output logic [4:0]  fill_level_o
);

  localparam int unsigned OCC_W = $clog2(QUEUE_DEPTH + 1);

  // input register
  logic             in_valid_q;
  logic             req_type_q;
  logic [31:0]      now_q;
  logic             link_up_q;
  logic             accepted_q;
  rleq_pkg::event_t evt_q;

  // result register
  logic             out_valid_q;
  logic             send_valid_q;
  rleq_pkg::event_t out_evt_q;
  logic             sync_q;
  logic             dropped_q;
  logic [4:0]       fill_q;

  logic                 advance;
  logic                 proc;
  logic                 is_enq;
  logic                 tick_up;
  logic                 attempt;
  logic                 sync_hit;
  logic                 drop;
  rleq_pkg::ring_cmd_t  ring_cmd;
  rleq_pkg::ring_sts_t  ring_sts;
  rleq_pkg::event_t     head;
  logic [OCC_W-1:0]     occ_nxt;
  rleq_pkg::timer_upd_t tmr_upd;
  rleq_pkg::timer_due_t tmr_due;

  // pipeline moves when the result register is free or drained
  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = in_valid_q && !advance;
  assign proc       = in_valid_q && advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      req_type_q            <= req_type_i;
      now_q                 <= now_ms_i;
      link_up_q             <= link_up_i;
      accepted_q            <= send_accepted_i;
      evt_q.compartment     <= compartment_i;
      evt_q.kind            <= event_kind_i;
      evt_q.value           <= event_value_i;
      evt_q.stamp           <= stamp_minutes_i;
    end
  end

  // decode of the registered transaction
  assign is_enq   = (req_type_q == rleq_pkg::REQ_ENQ);
  assign tick_up  = (req_type_q == rleq_pkg::REQ_TICK) && link_up_q;
  assign attempt  = tick_up && !ring_sts.empty && tmr_due.send;
  assign sync_hit = tick_up && tmr_due.sync;
  assign drop     = is_enq && ring_sts.full;

  // ring and timer commands, gated by the transaction moving on
  assign ring_cmd.push   = proc && is_enq;
  assign ring_cmd.pop    = proc && ((attempt && accepted_q) || drop);
  assign tmr_upd.attempt = proc && attempt;
  assign tmr_upd.sync    = proc && sync_hit;

  rleq_ring #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_ring (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (ring_cmd),
    .wdata_i   (evt_q),
    .head_o    (head),
    .sts_o     (ring_sts),
    .occ_nxt_o (occ_nxt)
  );

  rleq_timers u_timers (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .now_i       (now_q),
    .upd_i       (tmr_upd),
    .due_o       (tmr_due)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc) begin
      send_valid_q <= attempt;
      out_evt_q    <= attempt ? head : '0;
      sync_q       <= sync_hit;
      dropped_q    <= drop;
      fill_q       <= 5'(occ_nxt);
    end
  end

  assign out_valid_o       = out_valid_q;
  assign send_valid_o      = send_valid_q;
  assign out_compartment_o = out_evt_q.compartment;
  assign out_kind_o        = out_evt_q.kind;
  assign out_value_o       = out_evt_q.value;
  assign out_stamp_o       = out_evt_q.stamp;
  assign sync_request_o    = sync_q;
  assign dropped_oldest_o  = dropped_q;
  assign fill_level_o      = fill_q;

  // occupancy never passes the ring depth
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_nxt <= OCC_W'(QUEUE_DEPTH))
    else $error("ring occupancy beyond depth");

  // a pop only happens on a non-empty ring
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ring_cmd.pop |-> !ring_sts.empty)
    else $error("pop on empty ring");

  // a drop result carries no presentation and no sync request
  a_drop_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && dropped_oldest_o |-> !send_valid_o && !sync_request_o)
    else $error("drop result with tick fields set");

  // a drop leaves the ring full
  a_drop_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ring_cmd.push && ring_sts.full |=> ring_sts.full)
    else $error("ring not full after drop");

endmodule
